// File: rtl/multi_channel_ring_buffer_core_assert.svh
// ---------------------------------------------------------------------------
// multi_channel_ring_buffer_core assertion macros
// shared property forms for the ring buffer core checks
// ---------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_RING_BUFFER_CORE_ASSERT_SVH
`define MULTI_CHANNEL_RING_BUFFER_CORE_ASSERT_SVH

// same-cycle implication, quiet during reset
`define MCRB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mcrb check failed");

// next-cycle implication, quiet during reset
`define MCRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mcrb check failed");

`endif

// File: rtl/mcrb_pkg.sv
// ---------------------------------------------------------------------------
// mcrb_pkg
// constants, payload types and helpers of the multi-channel ring buffer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mcrb_pkg;

   localparam int PORTS         = 3;
   localparam int MAX_SIZE_LOG2 = 8;
   localparam int REG_PORTS     = 3;

   localparam int RINGS       = 2 * PORTS;
   localparam int RING_W      = (RINGS > 1) ? $clog2(RINGS) : 1;
   localparam int OFS_W       = MAX_SIZE_LOG2;
   localparam int STORE_DEPTH = RINGS << MAX_SIZE_LOG2;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int PTR_W       = 16;
   localparam int LOG2_W      = 4;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_W       = (RINGS > LOG2_W) ? RINGS : LOG2_W;

   localparam logic [LOG2_W-1:0] SIZE_LOG2_RESET = LOG2_W'(8);

   // opcodes
   localparam logic [2:0] OP_PUT_TX   = 3'd0;
   localparam logic [2:0] OP_PUT_RX   = 3'd1;
   localparam logic [2:0] OP_GET_RX   = 3'd2;
   localparam logic [2:0] OP_GET_TX   = 3'd3;
   localparam logic [2:0] OP_COUNT_RX = 3'd4;
   localparam logic [2:0] OP_COUNT_TX = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ENABLE_MASK = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_FIRST  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_LAST   = CSR_IDX_W'(2 * REG_PORTS);

   typedef struct packed {
      logic [2:0] opcode;
      logic [1:0] port;
      logic [7:0] data_in;
   } req_type;

   typedef struct packed {
      logic [7:0] data_out;
      logic [7:0] fill_count;
      logic       has_data;
      logic       enabled;
   } rsp_type;

   // offset mask of a ring, size clamped to the region size
   function automatic logic [OFS_W-1:0] size_mask(input logic [LOG2_W-1:0] k);
      logic [LOG2_W-1:0] kc;
      logic [OFS_W:0]    one_hot;
      kc      = (32'(k) > MAX_SIZE_LOG2) ? LOG2_W'(MAX_SIZE_LOG2) : k;
      one_hot = (OFS_W+1)'(1) << kc;
      return OFS_W'(one_hot - (OFS_W+1)'(1));
   endfunction

endpackage

// File: rtl/multi_channel_ring_buffer_core.sv
// ---------------------------------------------------------------------------
// multi_channel_ring_buffer_core
// six byte rings (transmit and receive for three ports) in one shared store
// ---------------------------------------------------------------------------
// One request per clock once the store is cleared, unless a stalled
// response holds the middle stage. After reset the core writes zero through
// all 1536 bytes of the byte store, one byte a cycle, and holds req_stall
// high meanwhile; configuration writes are taken at any time. A request is
// served by a single access to the byte store at the accept edge (write for
// put, read for get) while the ring's pointers, kept in flip-flops, are
// updated on that same edge, so back to back requests never need forwarding.
// The response passes through the registered store read and then the output
// register, which lets a new request enter while a response waits.
`timescale 1ns / 1ps
`include "multi_channel_ring_buffer_core_assert.svh"

module multi_channel_ring_buffer_core (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  mcrb_pkg::req_type               req_data,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output mcrb_pkg::rsp_type               rsp_data,
   // register write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mcrb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mcrb_pkg::CSR_W-1:0]      csr_data
);

   import mcrb_pkg::*;

   // byte store, read data registered
   logic [7:0]        store_mem [STORE_DEPTH];
   logic [7:0]        rd_data_ff;
   logic              mem_we;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_waddr;
   logic [ADDR_W-1:0] mem_raddr;
   logic [7:0]        mem_wdata;

   // clearing pass after reset
   logic              clr_busy_ff, clr_busy_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   // ring state
   logic [PTR_W-1:0]  wp_ff [RINGS];
   logic [PTR_W-1:0]  wp_in [RINGS];
   logic [PTR_W-1:0]  rp_ff [RINGS];
   logic [PTR_W-1:0]  rp_in [RINGS];
   logic [RINGS-1:0]  enable_ff, enable_in;
   logic [LOG2_W-1:0] size_log2_ff [RINGS];
   logic [LOG2_W-1:0] size_log2_in [RINGS];

   // middle stage: result fields waiting for the store read
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_get_ff, s1_get_in;
   logic [7:0]        s1_data_ff, s1_data_in;
   logic [7:0]        s1_count_ff, s1_count_in;
   logic              s1_en_ff, s1_en_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   // request decode
   logic              req_acc;
   logic              s1_adv;
   logic              op_ok;
   logic              port_ok;
   logic              dir_rx;
   logic              is_put;
   logic              is_get;
   logic              ring_en;
   logic              act;
   logic [RING_W-1:0] ring;
   logic [OFS_W-1:0]  ring_msk;
   logic [PTR_W-1:0]  wp_new;
   logic [PTR_W-1:0]  rp_new;
   logic [PTR_W-1:0]  ptr_diff;

   // register write decode
   logic              csr_acc;
   logic [CSR_IDX_W-1:0] size_idx;
   logic              size_dir;
   logic [CSR_IDX_W-1:0] size_port;
   logic              size_hit;
   logic [RING_W-1:0] size_ring;
   logic [RINGS-1:0]  en_rising;

   // ---------------------------------------------------------------------
   // handshakes
   // ---------------------------------------------------------------------
   assign csr_ready = 1'b1;
   assign csr_acc   = csr_valid & csr_ready;

   // middle stage moves on when the output register is free or drains
   assign s1_adv    = s1_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = clr_busy_ff | (s1_valid_ff & ~s1_adv);
   assign req_acc   = req_valid & ~req_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------------
   // request decode: which ring, which access
   // ---------------------------------------------------------------------
   always_comb begin
      op_ok   = (req_data.opcode <= OP_COUNT_TX);
      port_ok = (32'(req_data.port) < PORTS);
      dir_rx  = (req_data.opcode == OP_PUT_RX) || (req_data.opcode == OP_GET_RX) ||
                (req_data.opcode == OP_COUNT_RX);
      is_put  = (req_data.opcode == OP_PUT_TX) || (req_data.opcode == OP_PUT_RX);
      is_get  = (req_data.opcode == OP_GET_TX) || (req_data.opcode == OP_GET_RX);
      // an out of range port is steered to ring 0 and masked off by port_ok
      if (port_ok) begin
         ring = dir_rx ? RING_W'(32'(req_data.port) + PORTS) : RING_W'(req_data.port);
      end else begin
         ring = '0;
      end
      ring_en  = enable_ff[ring];
      act      = op_ok & port_ok & ring_en;
      ring_msk = size_mask(size_log2_ff[ring]);
      wp_new   = wp_ff[ring] + ((act & is_put) ? PTR_W'(1) : PTR_W'(0));
      rp_new   = rp_ff[ring] + ((act & is_get) ? PTR_W'(1) : PTR_W'(0));
      ptr_diff = wp_new - rp_new;
   end

   // ---------------------------------------------------------------------
   // register write decode
   // ---------------------------------------------------------------------
   always_comb begin
      size_idx  = csr_index - REG_SIZE_FIRST;
      size_dir  = (32'(size_idx) >= REG_PORTS);
      size_port = size_dir ? CSR_IDX_W'(32'(size_idx) - REG_PORTS) : size_idx;
      size_hit  = csr_acc && (csr_index >= REG_SIZE_FIRST) &&
                  (csr_index <= REG_SIZE_LAST) && (32'(size_port) < PORTS);
      if (size_hit) begin
         size_ring = size_dir ? RING_W'(32'(size_port) + PORTS) : RING_W'(size_port);
      end else begin
         size_ring = '0;
      end
      // a ring switched on starts empty
      en_rising = (csr_acc && (csr_index == REG_ENABLE_MASK)) ?
                  (csr_data[RINGS-1:0] & ~enable_ff) : '0;
   end

   // ---------------------------------------------------------------------
   // ring state next values
   // ---------------------------------------------------------------------
   always_comb begin
      enable_in = enable_ff;
      if (csr_acc && (csr_index == REG_ENABLE_MASK)) begin
         enable_in = csr_data[RINGS-1:0];
      end
      for (int r = 0; r < RINGS; r++) begin
         wp_in[r]        = wp_ff[r];
         rp_in[r]        = rp_ff[r];
         size_log2_in[r] = size_log2_ff[r];
         // pointer advance of the accepted request
         if (req_acc && act && (ring == RING_W'(r))) begin
            wp_in[r] = wp_new;
            rp_in[r] = rp_new;
         end
         // size write or enable rising clears the ring
         if (size_hit && (size_ring == RING_W'(r))) begin
            size_log2_in[r] = csr_data[LOG2_W-1:0];
            wp_in[r]        = '0;
            rp_in[r]        = '0;
         end
         if (en_rising[r]) begin
            wp_in[r] = '0;
            rp_in[r] = '0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // byte store access
   // ---------------------------------------------------------------------
   always_comb begin
      mem_re    = req_acc & act & is_get;
      mem_raddr = {ring, rp_ff[ring][OFS_W-1:0] & ring_msk};
      if (clr_busy_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = req_acc & act & is_put;
         mem_waddr = {ring, wp_ff[ring][OFS_W-1:0] & ring_msk};
         mem_wdata = req_data.data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= store_mem[mem_raddr];
      end
   end

   // clearing sweep over the whole store
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(STORE_DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // middle stage and output register
   // ---------------------------------------------------------------------
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_get_in   = s1_get_ff;
      s1_data_in  = s1_data_ff;
      s1_count_in = s1_count_ff;
      s1_en_in    = s1_en_ff;
      if (req_acc) begin
         s1_valid_in = 1'b1;
         s1_get_in   = act & is_get;
         // put tx echoes its byte, everything else without a read gives zero
         s1_data_in  = (act && (req_data.opcode == OP_PUT_TX)) ? req_data.data_in : 8'd0;
         s1_count_in = act ? 8'(ptr_diff[OFS_W-1:0] & ring_msk) : 8'd0;
         s1_en_in    = act;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (s1_adv) begin
         rsp_valid_in       = 1'b1;
         rsp_in.data_out    = s1_get_ff ? rd_data_ff : s1_data_ff;
         rsp_in.fill_count  = s1_count_ff;
         rsp_in.has_data    = (s1_count_ff != 8'd0);
         rsp_in.enabled     = s1_en_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         enable_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < RINGS; r++) begin
            wp_ff[r]        <= '0;
            rp_ff[r]        <= '0;
            size_log2_ff[r] <= SIZE_LOG2_RESET;
         end
      end else begin
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
         enable_ff    <= enable_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int r = 0; r < RINGS; r++) begin
            wp_ff[r]        <= wp_in[r];
            rp_ff[r]        <= rp_in[r];
            size_log2_ff[r] <= size_log2_in[r];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_get_ff   <= s1_get_in;
      s1_data_ff  <= s1_data_in;
      s1_count_ff <= s1_count_in;
      s1_en_ff    <= s1_en_in;
      rsp_ff      <= rsp_in;
   end

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
   // no request gets in while the store is still being cleared
   `MCRB_ASSERT_NOW(a_no_req_while_clearing, clock, reset, req_acc, !clr_busy_ff)
   // a waiting result in the middle stage is not lost behind a stalled output
   `MCRB_ASSERT_NEXT(a_s1_holds, clock, reset,
      s1_valid_ff && rsp_valid_ff && rsp_stall, s1_valid_ff)
   // a disabled ring answers all zero
   `MCRB_ASSERT_NOW(a_disabled_zero, clock, reset, rsp_valid_ff && !rsp_ff.enabled,
      rsp_ff.data_out == 8'd0 && rsp_ff.fill_count == 8'd0 && !rsp_ff.has_data)
   // has_data follows the count
   `MCRB_ASSERT_NOW(a_has_data, clock, reset, rsp_valid_ff,
      rsp_ff.has_data == (rsp_ff.fill_count != 8'd0))

endmodule

// File: tb/mcrb_reply_check.sv
// ---------------------------------------------------------------------------
// mcrb_reply_check
// watches the request, response and register channels of the ring buffer
// core, keeps its own copy of the rings and compares every response
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcrb_reply_check (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  mcrb_pkg::req_type               req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  mcrb_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [mcrb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mcrb_pkg::CSR_W-1:0]      csr_data,
   output int                              error_count,
   output int                              pending_count
);

   import mcrb_pkg::*;

   localparam int STORE_BYTES = RINGS << MAX_SIZE_LOG2;

   logic [7:0]        byte_mem [STORE_BYTES];
   logic [15:0]       put_ptr [RINGS];
   logic [15:0]       get_ptr [RINGS];
   logic [RINGS-1:0]  ring_on;
   logic [LOG2_W-1:0] ring_log2 [RINGS];
   rsp_type           expected_replies [$];

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   // applies one request to the shadow rings and returns the response it should give
   function automatic rsp_type predict_reply(input req_type rq);
      rsp_type           rp;
      int                dir;
      int                ring;
      int                base;
      logic [LOG2_W-1:0] k;
      logic [7:0]        msk;
      logic [15:0]       diff;
      rp = '0;
      if (rq.opcode > OP_COUNT_TX || rq.port >= PORTS) return rp;
      dir  = (rq.opcode == OP_PUT_RX || rq.opcode == OP_GET_RX || rq.opcode == OP_COUNT_RX)
             ? 1 : 0;
      ring = dir * PORTS + int'(rq.port);
      if (!ring_on[ring]) return rp;
      // sizes above the region size act as the region size
      k    = (ring_log2[ring] > MAX_SIZE_LOG2) ? LOG2_W'(MAX_SIZE_LOG2) : ring_log2[ring];
      msk  = 8'((9'd1 << k) - 9'd1);
      base = ring << MAX_SIZE_LOG2;
      case (rq.opcode)
         OP_PUT_TX, OP_PUT_RX: begin
            byte_mem[base + int'(put_ptr[ring] & 16'(msk))] = rq.data_in;
            put_ptr[ring] = put_ptr[ring] + 16'd1;
            if (rq.opcode == OP_PUT_TX) rp.data_out = rq.data_in;
         end
         OP_GET_RX, OP_GET_TX: begin
            rp.data_out = byte_mem[base + int'(get_ptr[ring] & 16'(msk))];
            get_ptr[ring] = get_ptr[ring] + 16'd1;
         end
         default: ;
      endcase
      diff          = put_ptr[ring] - get_ptr[ring];
      rp.fill_count = diff[7:0] & msk;
      rp.has_data   = (rp.fill_count != 8'd0);
      rp.enabled    = 1'b1;
      return rp;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      int      i;
      int      sel;
      int      ring;
      if (reset) begin
         for (i = 0; i < STORE_BYTES; i++) byte_mem[i] = 8'd0;
         for (i = 0; i < RINGS; i++) begin
            put_ptr[i]   = '0;
            get_ptr[i]   = '0;
            ring_log2[i] = SIZE_LOG2_RESET;
         end
         ring_on = '0;
         expected_replies.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_ENABLE_MASK) begin
               // a ring that turns on starts empty
               for (i = 0; i < RINGS; i++)
                  if (csr_data[i] && !ring_on[i]) begin
                     put_ptr[i] = '0;
                     get_ptr[i] = '0;
                  end
               ring_on = csr_data[RINGS-1:0];
            end else if (csr_index >= REG_SIZE_FIRST && csr_index <= REG_SIZE_LAST) begin
               sel = int'(csr_index - REG_SIZE_FIRST);
               if (sel % REG_PORTS < PORTS) begin
                  ring            = (sel / REG_PORTS) * PORTS + sel % REG_PORTS;
                  ring_log2[ring] = csr_data[LOG2_W-1:0];
                  put_ptr[ring]   = '0;
                  get_ptr[ring]   = '0;
               end
            end
         end
         if (req_valid && !req_stall) expected_replies.push_back(predict_reply(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_replies.size() == 0) begin
               report_mismatch($sformatf("response %h with no request outstanding", rsp_data));
            end else begin
               want = expected_replies.pop_front();
               if (rsp_data.data_out !== want.data_out)
                  report_mismatch($sformatf("data_out got %h expected %h",
                                            rsp_data.data_out, want.data_out));
               if (rsp_data.fill_count !== want.fill_count)
                  report_mismatch($sformatf("fill_count got %h expected %h",
                                            rsp_data.fill_count, want.fill_count));
               if (rsp_data.has_data !== want.has_data)
                  report_mismatch($sformatf("has_data got %b expected %b",
                                            rsp_data.has_data, want.has_data));
               if (rsp_data.enabled !== want.enabled)
                  report_mismatch($sformatf("enabled got %b expected %b",
                                            rsp_data.enabled, want.enabled));
            end
         end
      end
      pending_count = expected_replies.size();
   end

endmodule

// File: tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// drives the multi-channel ring buffer core with directed and random
// requests under random stalls and register settings; a checker beside
// the core predicts every response and counts mismatches
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   import mcrb_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int RESET_CYCLES    = 10;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int PHASES          = 6;
   localparam int PHASE_ITEMS     = 300;
   localparam int SETTLE_CYCLES   = 8;
   localparam int IDLE_PCT        = 30;
   localparam int DIR_TX          = 0;
   localparam int DIR_RX          = 1;

   // opcodes and port the core has no use for
   localparam logic [2:0] OP_UNUSED_LO = 3'd6;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;
   localparam logic [1:0] PORT_NONE    = 2'd3;
   // register index just past the last size register
   localparam logic [CSR_IDX_W-1:0] REG_PAST_END = CSR_IDX_W'(2 * REG_PORTS + 1);

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_data;

   int   error_count;
   int   pending_count;
   int   cycle_count = 0;

   // idling knobs, changed between phases
   int   send_idle_pct;
   int   stall_pct;

   // receiver hold-off: flipping hold_toggle starts one long stall
   logic hold_toggle;
   logic hold_seen = 1'b0;
   int   hold_left = 0;

   multi_channel_ring_buffer_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   mcrb_reply_check u_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog; the bound covers the store clearing pass and every stall
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // response side: random stalls, or one long hold-off when asked
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_toggle != hold_seen) begin
         hold_seen = hold_toggle;
         hold_left = HOLD_OFF_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // offers one request, with random idle cycles first, and returns at the
   // falling edge after it was taken; valid stays high into the next request
   task automatic send_op(input logic [2:0] op, input logic [1:0] prt, input logic [7:0] din);
      req_type rq;
      rq.opcode  = op;
      rq.port    = prt;
      rq.data_in = din;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // one register write, then csr_valid is dropped before the task returns
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_size(input int dir, input int prt, input int log2);
      write_reg(CSR_IDX_W'(int'(REG_SIZE_FIRST) + dir * REG_PORTS + prt), CSR_W'(log2));
   endtask

   // stop offering and wait until every response is back, plus pipeline slack
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      int         p;
      int         i;
      int         served;
      int         pick;
      logic [2:0] op;
      logic [1:0] prt;

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_stall     = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_data      = '0;
      hold_toggle   = 1'b0;
      send_idle_pct = IDLE_PCT;
      stall_pct     = IDLE_PCT;

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---------------- directed part ----------------
      // all rings on, a spread of sizes: one byte, tiny, clamped, full region
      write_reg(REG_ENABLE_MASK, CSR_W'(6'h3F));
      set_size(DIR_TX, 0, 0);
      set_size(DIR_TX, 1, 2);
      set_size(DIR_TX, 2, 15);
      set_size(DIR_RX, 0, 8);
      set_size(DIR_RX, 1, 1);
      set_size(DIR_RX, 2, 3);
      // index past the list must leave everything alone
      write_reg(REG_PAST_END, CSR_W'(6'h00));

      // get from an empty ring sees the cleared store
      send_op(OP_GET_RX, 2'd0, 8'h00);
      // one-byte ring: count always zero, second put overwrites the first
      send_op(OP_PUT_TX, 2'd0, 8'hFF);
      send_op(OP_PUT_TX, 2'd0, 8'h00);
      send_op(OP_GET_TX, 2'd0, 8'hFF);
      // plain put, count and get on the full-size receive ring
      send_op(OP_PUT_RX, 2'd0, 8'hA5);
      send_op(OP_COUNT_RX, 2'd0, 8'h00);
      send_op(OP_GET_RX, 2'd0, 8'h00);
      // overfill a four-byte ring so it wraps and a full ring counts zero
      for (i = 0; i < 5; i++) send_op(OP_PUT_TX, 2'd1, 8'(8'h11 * (i + 1)));
      send_op(OP_COUNT_TX, 2'd1, 8'h00);
      send_op(OP_GET_TX, 2'd1, 8'h00);
      send_op(OP_PUT_RX, 2'd2, 8'h80);
      // size above the region acts as the region size
      send_op(OP_PUT_TX, 2'd2, 8'h7F);
      send_op(OP_COUNT_TX, 2'd2, 8'h00);
      // get past the write pointer on a two-byte ring
      send_op(OP_GET_RX, 2'd1, 8'h00);
      // unused opcodes and the port past the last one give all zeros
      send_op(OP_UNUSED_LO, 2'd0, 8'h01);
      send_op(OP_UNUSED_HI, 2'd1, 8'h02);
      send_op(OP_PUT_TX, PORT_NONE, 8'h55);
      drain();

      // transmit rings off, receive rings still on
      write_reg(REG_ENABLE_MASK, CSR_W'(6'h38));
      send_op(OP_PUT_TX, 2'd0, 8'h5A);
      send_op(OP_GET_TX, 2'd1, 8'h00);
      send_op(OP_COUNT_RX, 2'd2, 8'h00);
      drain();
      // turning transmit back on empties those rings but keeps the old bytes
      write_reg(REG_ENABLE_MASK, CSR_W'(6'h3F));
      send_op(OP_GET_TX, 2'd1, 8'h00);
      drain();

      // ---------------- random part ----------------
      for (p = 0; p < PHASES; p++) begin
         case (p)
            0: begin
               // small rings wrap often
               for (i = 0; i < PORTS; i++) begin
                  set_size(DIR_TX, i, $urandom_range(3));
                  set_size(DIR_RX, i, $urandom_range(3));
               end
               write_reg(REG_ENABLE_MASK, CSR_W'(6'h3F));
            end
            2: begin
               // full-size rings, no idling, and one long hold-off so the
               // core backs up into the request channel
               for (i = 0; i < PORTS; i++) begin
                  set_size(DIR_TX, i, 8);
                  set_size(DIR_RX, i, 8);
               end
               write_reg(REG_ENABLE_MASK, CSR_W'(6'h3F));
               send_idle_pct <= 0;
               stall_pct     <= 0;
               hold_toggle   <= ~hold_toggle;
            end
            3: begin
               // extremes: one-byte transmit rings, oversized receive rings
               for (i = 0; i < PORTS; i++) begin
                  set_size(DIR_TX, i, 0);
                  set_size(DIR_RX, i, 15);
               end
               write_reg(REG_ENABLE_MASK, CSR_W'(6'h3F));
               send_idle_pct <= IDLE_PCT;
               stall_pct     <= IDLE_PCT;
            end
            5: begin
               for (i = 0; i < PORTS; i++) begin
                  set_size(DIR_TX, i, $urandom_range(4, 1));
                  set_size(DIR_RX, i, $urandom_range(4, 1));
               end
               write_reg(REG_ENABLE_MASK, CSR_W'(6'h00));
               write_reg(REG_ENABLE_MASK, CSR_W'(6'h3F));
            end
            default: begin
               // any size the field holds, random mix of rings on
               for (i = 0; i < PORTS; i++) begin
                  set_size(DIR_TX, i, $urandom_range(15));
                  set_size(DIR_RX, i, $urandom_range(15));
               end
               write_reg(REG_ENABLE_MASK, CSR_W'($urandom_range(63)));
            end
         endcase

         served = 0;
         while (served < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            prt  = ($urandom_range(19) == 0) ? PORT_NONE : 2'($urandom_range(PORTS - 1));
            if (pick < 22)      op = OP_PUT_TX;
            else if (pick < 44) op = OP_PUT_RX;
            else if (pick < 64) op = OP_GET_RX;
            else if (pick < 84) op = OP_GET_TX;
            else if (pick < 91) op = OP_COUNT_RX;
            else if (pick < 98) op = OP_COUNT_TX;
            else                op = $urandom_range(1) ? OP_UNUSED_HI : OP_UNUSED_LO;
            send_op(op, prt, 8'($urandom_range(255)));
            if (op <= OP_COUNT_TX && prt != PORT_NONE) served++;
         end
         // sender waits for every response before the next settings
         drain();
         if (p == 2) begin
            send_idle_pct <= IDLE_PCT;
            stall_pct     <= IDLE_PCT;
         end
      end

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
